@@ hw/rtl/light_sample_window_stats_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the light sample window statistics block
// Clocked on clk_i, quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LIGHT_SAMPLE_WINDOW_STATS_ASSERT_SVH
`define LIGHT_SAMPLE_WINDOW_STATS_ASSERT_SVH

// property that must hold at every edge out of reset
`define LSWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must be followed by another in the next cycle
`define LSWS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

@@ hw/rtl/lsws_pkg.sv @@
// ----------------------------------------------------------------------------
// lsws_pkg
// Shared types and constants of the light sample window statistics block.
// ----------------------------------------------------------------------------
package lsws_pkg;

  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned TS_W        = 40;
  localparam int unsigned GAVG_W      = 56;
  localparam int unsigned LAVG_W      = 28;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 17'd65470;
  localparam logic [SAMPLE_W-1:0] OFFSET_RST = 12'd910;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_REPORT = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMA_WEIGHT = 1'b0,
    CFG_DIP_OFFSET = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    action_e             action;
    logic [SAMPLE_W-1:0] sample;
    logic [TS_W-1:0]     ts;
  } item_t;

endpackage

@@ hw/rtl/light_sample_window_stats.sv @@
// ----------------------------------------------------------------------------
// light_sample_window_stats
// Windowed statistics over timestamped light samples with a dip counter.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+--------------------------
//  input     | in        | push / full               | action, sample, timestamp
//  result    | out       | pop / empty               | nine statistics fields
//  config    | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  In the back end, a sample word's six smoothing partial products are
//  registered, then summed, rounded and saturated. A report word walks
//  the store through its registered read port, then goes into the result
//  register once any earlier result has been popped.
//  The front queue holds two words; input is held off only once two words
//  wait behind a busy back end or an unpopped result. The config port never
//  stalls.
//  Reset is asynchronous, active low; the window store is never cleared,
//  since a report only reads entries written in the current window.
//
module light_sample_window_stats import lsws_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 1024,
  localparam int unsigned CntW = $clog2(BUFFER_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input queue side
  input  logic                  push,
  output logic                  full,
  input  logic                  action_i,
  input  logic [SAMPLE_W-1:0]   sample_i,
  input  logic [TS_W-1:0]       timestamp_ns_i,
  // result queue side
  output logic                  empty,
  input  logic                  pop,
  output logic [TS_W-1:0]       min_interval_ns_o,
  output logic [TS_W-1:0]       max_interval_ns_o,
  output logic [GAVG_W-1:0]     avg_interval_o,
  output logic [SAMPLE_W-1:0]   min_level_o,
  output logic [SAMPLE_W-1:0]   max_level_o,
  output logic [LAVG_W-1:0]     avg_level_o,
  output logic [CntW-1:0]       dip_count_o,
  output logic [CntW-1:0]       window_samples_o,
  output logic [TOTAL_W-1:0]    total_samples_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [WEIGHT_W-1:0] weight_q;
  logic [SAMPLE_W-1:0] offset_q;
  item_t               item;
  logic                item_vld, item_rdy, out_vld;

  // config registers: writes land at once, no back-pressure
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WEIGHT_RST;
      offset_q <= OFFSET_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_EMA_WEIGHT: weight_q <= cfg_data_i[WEIGHT_W-1:0];
        CFG_DIP_OFFSET: offset_q <= cfg_data_i[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  lsws_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .action_i       (action_i),
    .sample_i       (sample_i),
    .timestamp_ns_i (timestamp_ns_i),
    .item_o         (item),
    .item_vld_o     (item_vld),
    .item_rdy_i     (item_rdy)
  );

  lsws_back #(
    .BufferDepth (BUFFER_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .item_i            (item),
    .item_vld_i        (item_vld),
    .item_rdy_o        (item_rdy),
    .weight_i          (weight_q),
    .offset_i          (offset_q),
    .out_vld_o         (out_vld),
    .out_pop_i         (pop),
    .min_interval_ns_o (min_interval_ns_o),
    .max_interval_ns_o (max_interval_ns_o),
    .avg_interval_o    (avg_interval_o),
    .min_level_o       (min_level_o),
    .max_level_o       (max_level_o),
    .avg_level_o       (avg_level_o),
    .dip_count_o       (dip_count_o),
    .window_samples_o  (window_samples_o),
    .total_samples_o   (total_samples_o)
  );

  assign empty = ~out_vld;

endmodule

@@ hw/rtl/lsws_ram.sv @@
// ----------------------------------------------------------------------------
// lsws_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsws_ram #(
  parameter int unsigned Width = 12,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lsws_front.sv @@
// ----------------------------------------------------------------------------
// lsws_front
// Input side: takes words off the push port, tags their kind and holds them
// in a two-word queue for the back end.
// ----------------------------------------------------------------------------
module lsws_front import lsws_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic                action_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [TS_W-1:0]     timestamp_ns_i,
  output item_t               item_o,
  output logic                item_vld_o,
  input  logic                item_rdy_i
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  item_t           mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            push_ok, pop_ok;
  item_t           in_item;

  assign full       = (cnt_q == CntW'(QUEUE_DEPTH));
  assign item_vld_o = (cnt_q != '0);
  assign item_o     = mem_q[rp_q];
  assign push_ok    = push & ~full;
  assign pop_ok     = item_vld_o & item_rdy_i;

  always_comb begin
    in_item.action = action_i ? ACT_REPORT : ACT_SAMPLE;
    in_item.sample = sample_i;
    in_item.ts     = timestamp_ns_i;
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wp_q] <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) wp_q <= wp_q + 1'b1;
      if (pop_ok)  rp_q <= rp_q + 1'b1;
      case ({push_ok, pop_ok})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ hw/rtl/lsws_back.sv @@
// ----------------------------------------------------------------------------
// lsws_back
// Execution side: running statistics, window store, dip walk and the
// result register.
// ----------------------------------------------------------------------------
`include "light_sample_window_stats_assert.svh"

module lsws_back import lsws_pkg::*; #(
  parameter int unsigned BufferDepth = 1024,
  localparam int unsigned CntW = $clog2(BufferDepth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  item_t               item_i,
  input  logic                item_vld_i,
  output logic                item_rdy_o,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  logic [SAMPLE_W-1:0] offset_i,
  output logic                out_vld_o,
  input  logic                out_pop_i,
  output logic [TS_W-1:0]     min_interval_ns_o,
  output logic [TS_W-1:0]     max_interval_ns_o,
  output logic [GAVG_W-1:0]   avg_interval_o,
  output logic [SAMPLE_W-1:0] min_level_o,
  output logic [SAMPLE_W-1:0] max_level_o,
  output logic [LAVG_W-1:0]   avg_level_o,
  output logic [CntW-1:0]     dip_count_o,
  output logic [CntW-1:0]     window_samples_o,
  output logic [TOTAL_W-1:0]  total_samples_o
);

  localparam int unsigned AddrW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int unsigned PgW   = WEIGHT_W + TS_W;        // 57
  localparam int unsigned PlW   = WEIGHT_W + SAMPLE_W;    // 29
  localparam int unsigned PfW   = WEIGHT_W + FRAC_W;      // 33
  localparam int unsigned GsW   = PgW + 1;
  localparam int unsigned LsW   = PfW - 1;
  localparam int unsigned ThrW  = LAVG_W + 2;
  localparam logic [CntW-1:0] LastCnt = CntW'(BufferDepth - 1);
  localparam logic [GsW-1:0]  GMax    = GsW'({GAVG_W{1'b1}});
  localparam logic [LsW-1:0]  LMax    = LsW'({LAVG_W{1'b1}});

  typedef enum logic [1:0] {
    S_IDLE,
    S_SMOOTH,
    S_WALK,
    S_EMIT
  } state_e;

  state_e st_q;

  logic [CntW-1:0]     cnt_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [LAVG_W-1:0]   lavg_q;
  logic [SAMPLE_W-1:0] lmin_q, lmax_q;
  logic [TS_W-1:0]     prev_ts_q, gmin_q, gmax_q;
  logic [GAVG_W-1:0]   gavg_q;
  logic                wipe_q;
  logic [PgW-1:0]      pg1_q, pg2_q;
  logic [PfW-1:0]      pg3_q, pl3_q;
  logic [PlW-1:0]      pl1_q, pl2_q;

  logic [CntW-1:0]     idx_q, dip_q;
  logic                rd_vld_q, have_prev_q, in_dip_q;
  logic [SAMPLE_W-1:0] prev_s_q;
  logic signed [ThrW-1:0] thr_q;

  logic                out_vld_q;
  logic [TS_W-1:0]     o_gmin_q, o_gmax_q;
  logic [GAVG_W-1:0]   o_gavg_q;
  logic [SAMPLE_W-1:0] o_lmin_q, o_lmax_q;
  logic [LAVG_W-1:0]   o_lavg_q;
  logic [CntW-1:0]     o_dip_q, o_cnt_q;
  logic [TOTAL_W-1:0]  o_total_q;

  logic [WEIGHT_W-1:0] w, rest;
  logic [TS_W-1:0]     gap;
  logic                take_sample, take_report, rd_issue, emit;
  logic [GsW-1:0]      gsum;
  logic [LsW-1:0]      lsum;
  logic [SAMPLE_W-1:0] rdata;
  logic signed [ThrW-1:0] thr_now, a_val, b_val;
  logic                a_lt, b_gt, a_gt;

  assign item_rdy_o  = (st_q == S_IDLE);
  assign take_sample = item_rdy_o & item_vld_i & (item_i.action == ACT_SAMPLE);
  assign take_report = item_rdy_o & item_vld_i & (item_i.action == ACT_REPORT);
  assign rd_issue    = (st_q == S_WALK) & (idx_q < cnt_q);
  assign emit        = (st_q == S_EMIT) & (~out_vld_q | out_pop_i);

  // weights above one act as one
  assign w    = (weight_i > WEIGHT_ONE) ? WEIGHT_ONE : weight_i;
  assign rest = WEIGHT_ONE - w;
  assign gap  = item_i.ts - prev_ts_q;

  // accumulate the registered partial products, round half up, saturate
  assign gsum = GsW'(pg1_q) + GsW'(pg2_q) + GsW'((34'(pg3_q) + 34'd32768) >> FRAC_W);
  assign lsum = LsW'(pl1_q) + LsW'(pl2_q) + LsW'((34'(pl3_q) + 34'd32768) >> FRAC_W);

  assign thr_now = $signed({2'b00, lavg_q}) - $signed({2'b00, offset_i, {FRAC_W{1'b0}}});
  assign a_val   = $signed({2'b00, prev_s_q, {FRAC_W{1'b0}}});
  assign b_val   = $signed({2'b00, rdata, {FRAC_W{1'b0}}});
  assign a_lt    = a_val < thr_q;
  assign a_gt    = a_val > thr_q;
  assign b_gt    = b_val > thr_q;

  lsws_ram #(
    .Width (SAMPLE_W),
    .Depth (BufferDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (take_sample),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (item_i.sample),
    .re_i    (rd_issue),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      lavg_q      <= '0;
      lmin_q      <= '0;
      lmax_q      <= '0;
      prev_ts_q   <= '0;
      gmin_q      <= '0;
      gmax_q      <= '0;
      gavg_q      <= '0;
      wipe_q      <= 1'b0;
      pg1_q       <= '0;
      pg2_q       <= '0;
      pg3_q       <= '0;
      pl1_q       <= '0;
      pl2_q       <= '0;
      pl3_q       <= '0;
      idx_q       <= '0;
      dip_q       <= '0;
      rd_vld_q    <= 1'b0;
      have_prev_q <= 1'b0;
      in_dip_q    <= 1'b0;
      prev_s_q    <= '0;
      thr_q       <= '0;
      out_vld_q   <= 1'b0;
      o_gmin_q    <= '0;
      o_gmax_q    <= '0;
      o_gavg_q    <= '0;
      o_lmin_q    <= '0;
      o_lmax_q    <= '0;
      o_lavg_q    <= '0;
      o_dip_q     <= '0;
      o_cnt_q     <= '0;
      o_total_q   <= '0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_pop_i) begin
        out_vld_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (take_sample) begin
            pg1_q <= PgW'(w * gap);
            pg2_q <= PgW'(rest * gavg_q[GAVG_W-1:FRAC_W]);
            pg3_q <= PfW'(rest * gavg_q[FRAC_W-1:0]);
            pl1_q <= PlW'(w * item_i.sample);
            pl2_q <= PlW'(rest * lavg_q[LAVG_W-1:FRAC_W]);
            pl3_q <= PfW'(rest * lavg_q[FRAC_W-1:0]);
            if (total_q != '1) total_q <= total_q + 1'b1;
            prev_ts_q <= item_i.ts;
            // store full: the window restarts
            if (cnt_q == LastCnt) begin
              cnt_q  <= '0;
              lmin_q <= '0;
              lmax_q <= '0;
              gmin_q <= '0;
              gmax_q <= '0;
              wipe_q <= 1'b1;
            end else begin
              cnt_q  <= cnt_q + 1'b1;
              wipe_q <= 1'b0;
              if (cnt_q == '0) begin
                lmin_q <= item_i.sample;
                lmax_q <= item_i.sample;
                gmin_q <= gap;
              end else begin
                if (item_i.sample < lmin_q) lmin_q <= item_i.sample;
                if (item_i.sample > lmax_q) lmax_q <= item_i.sample;
                if (gap < gmin_q) gmin_q <= gap;
                if (gap > gmax_q) gmax_q <= gap;
              end
            end
            st_q <= S_SMOOTH;
          end else if (take_report) begin
            idx_q       <= '0;
            dip_q       <= '0;
            rd_vld_q    <= 1'b0;
            have_prev_q <= 1'b0;
            in_dip_q    <= 1'b0;
            thr_q       <= thr_now;
            st_q        <= S_WALK;
          end
        end
        S_SMOOTH: begin
          lavg_q <= (lsum > LMax) ? LAVG_W'(LMax) : lsum[LAVG_W-1:0];
          gavg_q <= wipe_q ? '0 : ((gsum > GMax) ? GAVG_W'(GMax) : gsum[GAVG_W-1:0]);
          st_q   <= S_IDLE;
        end
        S_WALK: begin
          rd_vld_q <= rd_issue;
          if (rd_issue) idx_q <= idx_q + 1'b1;
          if (rd_vld_q) begin
            prev_s_q    <= rdata;
            have_prev_q <= 1'b1;
            if (have_prev_q) begin
              if (a_lt && b_gt && !in_dip_q) begin
                dip_q    <= dip_q + 1'b1;
                in_dip_q <= 1'b1;
              end else if (a_gt && in_dip_q) begin
                in_dip_q <= 1'b0;
              end
            end
          end else if (!rd_issue) begin
            st_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit) begin
            o_gmin_q  <= (cnt_q == '0) ? '0 : gmin_q;
            o_gmax_q  <= (cnt_q < CntW'(2)) ? '0 : gmax_q;
            o_gavg_q  <= (cnt_q < CntW'(2)) ? '0 : gavg_q;
            o_lmin_q  <= (cnt_q == '0) ? '0 : lmin_q;
            o_lmax_q  <= (cnt_q == '0) ? '0 : lmax_q;
            o_lavg_q  <= lavg_q;
            o_dip_q   <= dip_q;
            o_cnt_q   <= cnt_q;
            o_total_q <= total_q;
            cnt_q     <= '0;
            lmin_q    <= '0;
            lmax_q    <= '0;
            gmin_q    <= '0;
            gmax_q    <= '0;
            gavg_q    <= '0;
            st_q      <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_vld_o         = out_vld_q;
  assign min_interval_ns_o = o_gmin_q;
  assign max_interval_ns_o = o_gmax_q;
  assign avg_interval_o    = o_gavg_q;
  assign min_level_o       = o_lmin_q;
  assign max_level_o       = o_lmax_q;
  assign avg_level_o       = o_lavg_q;
  assign dip_count_o       = o_dip_q;
  assign window_samples_o  = o_cnt_q;
  assign total_samples_o   = o_total_q;

  `LSWS_ASSERT(a_cnt_below_depth, cnt_q < CntW'(BufferDepth), "window count reached depth")
  `LSWS_ASSERT(a_dips_bounded, st_q != S_WALK || dip_q <= cnt_q, "more dips than samples")
  `LSWS_ASSERT_NEXT(a_read_returns, rd_issue, rd_vld_q, "store read lost in walk")
  `LSWS_ASSERT_NEXT(a_emit_shows, emit, out_vld_q && st_q == S_IDLE, "report not loaded")

endmodule
